// ===== hdl/wavhc_pkg.sv =====
// shared types, constants and tag table for the wav header check and sample unpacker
package wavhc_pkg;

  // header layout and checks
  localparam logic [5:0]  POS_RATE_MUL   = 6'd34;
  localparam logic [5:0]  POS_RATE_CMP   = 6'd35;
  localparam logic [5:0]  POS_ALIGN_MUL  = 6'd36;
  localparam logic [5:0]  POS_ALIGN_CMP  = 6'd37;
  localparam logic [5:0]  POS_HDR_LAST   = 6'd43;
  localparam logic [31:0] HEADER_BYTES   = 32'd44;
  localparam logic [31:0] FMT_LEN        = 32'd16;
  localparam logic [15:0] PCM_FORMAT     = 16'd1;
  localparam logic [15:0] BITS_EIGHT     = 16'd8;
  localparam logic [15:0] BITS_SIXTEEN   = 16'd16;
  localparam logic [15:0] CHANS_MONO     = 16'd1;
  localparam logic [15:0] CHANS_STEREO   = 16'd2;
  // data size + 44 == riff size + 8, folded into one constant
  localparam logic [32:0] DATA_SIZE_GAP  = 33'd36;
  localparam logic [7:0]  EIGHT_BIT_FLIP = 8'h80;

  // result buffer depth in byte results (each holds one or two beats)
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_IDLE   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_HEADER  = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_TRUNCATED   = 3'd4
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] value;
    logic               chan;
    status_e            status;
    logic [31:0]        rate;
    logic [15:0]        chans;
    logic [15:0]        bits;
  } res_t;

  // everything one byte produces: one or two results
  typedef struct packed {
    logic two;
    res_t res0;
    res_t res1;
  } pair_t;

  typedef struct packed {
    logic       check;
    logic [7:0] expect_byte;
  } tag_t;

  // expected tag character at a header position, if that position holds a tag
  function automatic tag_t tag_lookup(input logic [5:0] pos);
    tag_t t;
    t.check = 1'b1;
    unique case (pos)
      6'd0:  t.expect_byte = "R";
      6'd1:  t.expect_byte = "I";
      6'd2:  t.expect_byte = "F";
      6'd3:  t.expect_byte = "F";
      6'd8:  t.expect_byte = "W";
      6'd9:  t.expect_byte = "A";
      6'd10: t.expect_byte = "V";
      6'd11: t.expect_byte = "E";
      6'd12: t.expect_byte = "f";
      6'd13: t.expect_byte = "m";
      6'd14: t.expect_byte = "t";
      6'd15: t.expect_byte = " ";
      6'd36: t.expect_byte = "d";
      6'd37: t.expect_byte = "a";
      6'd38: t.expect_byte = "t";
      6'd39: t.expect_byte = "a";
      default: begin
        t.check       = 1'b0;
        t.expect_byte = 8'd0;
      end
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/wavhc_byte_if.sv =====
// byte stream channel: valid/ready with the file byte and its framing flags
interface wavhc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;
  logic       file_end;

  modport source (output valid, output data_byte, output file_start, output file_end,
                  input ready);
  modport sink   (input valid, input data_byte, input file_start, input file_end,
                  output ready);
endinterface

// ===== hdl/wavhc_result_if.sv =====
// result channel: valid/ready with one decoded sample or status per beat
interface wavhc_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [15:0] sample_value;
  logic               sample_channel;
  logic [2:0]         status_code;
  logic [31:0]        sample_rate;
  logic [15:0]        channel_count;
  logic [15:0]        bits_per_sample;
  logic               last_of_run;

  modport source (output valid, output result_kind, output sample_value,
                  output sample_channel, output status_code, output sample_rate,
                  output channel_count, output bits_per_sample, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input sample_value,
                  input sample_channel, input status_code, input sample_rate,
                  input channel_count, input bits_per_sample, input last_of_run,
                  output ready);
endinterface

// ===== hdl/wavhc_parser.sv =====
// input register, header assembly and checks, sample decode, one byte per cycle while the result buffer has room
module wavhc_parser import wavhc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  wavhc_byte_if.sink   in_i,
  input  logic         room_i,
  output logic         push_o,
  output pair_t        pair_o
);

  // input register
  logic       in_v_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       end_q;
  logic       accept;
  logic       consume;

  // parse state
  logic [31:0] pos_q, pos_d;
  phase_e      phase_q, phase_d;
  logic        mism_q, mism_d;
  logic [31:0] riff_q, riff_d;
  logic [31:0] fmt_q, fmt_d;
  logic [15:0] fmttag_q, fmttag_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] brate_q, brate_d;
  logic [15:0] balign_q, balign_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] dsize_q, dsize_d;
  logic [7:0]  low_q, low_d;
  logic        tog_q, tog_d;
  logic        shift_eight_bit_q;

  // header cross checks, prepared while the tail of the header streams in
  logic [47:0] prod_q, prod_d;
  logic [28:0] aprod_q, aprod_d;
  logic        rate_ok_q;
  logic        align_ok_q;

  // start of file restarts the parse for this byte
  logic [31:0] pos_e;
  phase_e      phase_e_s;
  logic        mism_e;
  logic        tog_e;
  logic [5:0]  hpos;
  tag_t        tag;

  logic [31:0] dsize_fin;
  logic        size_ok;
  logic        hdr_bad;
  logic        fmt_supp;
  status_e     hdr_st;

  logic [31:0] count;
  logic [31:0] counted;
  logic        pos_max;
  logic        is8;
  logic        stereo;
  logic        have;
  logic [15:0] smp_value;
  logic [1:0]  align_mask;
  status_e     data_end_st;
  status_e     eof_st;

  res_t        smp_r, hdr_r, eof_r;

  assign accept     = in_i.valid && in_i.ready;
  assign consume    = in_v_q && room_i;
  assign in_i.ready = !in_v_q || room_i;

  // input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (accept) begin
      in_v_q <= 1'b1;
    end else if (consume) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= in_i.data_byte;
      start_q <= in_i.file_start;
      end_q   <= in_i.file_end;
    end
  end

  // effective state for the byte in the input register
  assign pos_e     = start_q ? 32'd0 : pos_q;
  assign phase_e_s = start_q ? PH_HEADER : phase_q;
  assign mism_e    = start_q ? 1'b0 : mism_q;
  assign tog_e     = start_q ? 1'b0 : tog_q;
  assign hpos      = pos_e[5:0];
  assign tag       = tag_lookup(hpos);

  // final header checks, data size completes with this byte
  assign dsize_fin = {byte_q, dsize_q[23:0]};
  assign size_ok   = ({1'b0, dsize_fin} + DATA_SIZE_GAP) == {1'b0, riff_q};
  assign hdr_bad   = mism_e || (fmt_q != FMT_LEN) || (fmttag_q != PCM_FORMAT)
                     || !align_ok_q || !rate_ok_q || !size_ok;
  assign fmt_supp  = ((bits_q == BITS_EIGHT) || (bits_q == BITS_SIXTEEN))
                     && ((chan_q == CHANS_MONO) || (chan_q == CHANS_STEREO));

  always_comb begin
    priority if (hdr_bad) begin
      hdr_st = ST_BAD_HEADER;
    end else if (!fmt_supp) begin
      hdr_st = ST_UNSUPPORTED;
    end else begin
      hdr_st = ST_OK;
    end
  end

  // cross-check products
  assign prod_d  = rate_q * balign_q;
  assign aprod_d = bits_q[15:3] * chan_q;

  // sample decode
  assign count      = pos_q - HEADER_BYTES;
  assign counted    = count + 32'd1;
  assign pos_max    = &pos_q;
  assign is8        = bits_q == BITS_EIGHT;
  assign stereo     = chan_q == CHANS_STEREO;
  assign have       = is8 || count[0];
  // block align is 1, 2 or 4 here, so the frame check is a mask
  assign align_mask = balign_q[1:0] - 2'd1;

  always_comb begin
    if (is8) begin
      if (shift_eight_bit_q) begin
        smp_value = {{8{~byte_q[7]}}, byte_q ^ EIGHT_BIT_FLIP};
      end else begin
        smp_value = {8'd0, byte_q};
      end
    end else begin
      smp_value = {byte_q, low_q};
    end
  end

  assign data_end_st = ((mism_q || pos_max) || (counted != dsize_q)
                        || ((counted[1:0] & align_mask) != 2'd0))
                       ? ST_LEN_MISMATCH : ST_OK;

  // end-of-file status code by phase
  always_comb begin
    if (phase_e_s == PH_DATA) begin
      eof_st = data_end_st;
    end else if (hpos == POS_HDR_LAST) begin
      eof_st = (dsize_fin == 32'd0) ? ST_OK : ST_LEN_MISMATCH;
    end else begin
      eof_st = ST_TRUNCATED;
    end
  end

  // result templates
  always_comb begin
    smp_r        = '0;
    smp_r.kind   = KIND_SAMPLE;
    smp_r.value  = smp_value;
    smp_r.chan   = stereo && !tog_q;

    hdr_r        = '0;
    hdr_r.kind   = KIND_HEADER;
    hdr_r.status = hdr_st;
    hdr_r.rate   = rate_q;
    hdr_r.chans  = chan_q;
    hdr_r.bits   = bits_q;

    eof_r        = '0;
    eof_r.kind   = KIND_END;
    eof_r.status = eof_st;
  end

  // next state and results for the byte being consumed
  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    mism_d   = mism_q;
    riff_d   = riff_q;
    fmt_d    = fmt_q;
    fmttag_d = fmttag_q;
    chan_d   = chan_q;
    rate_d   = rate_q;
    brate_d  = brate_q;
    balign_d = balign_q;
    bits_d   = bits_q;
    dsize_d  = dsize_q;
    low_d    = low_q;
    tog_d    = tog_q;
    push_o   = 1'b0;
    pair_o   = '0;
    if (consume) begin
      unique case (phase_e_s)
        PH_HEADER: begin
          tog_d  = tog_e;
          mism_d = mism_e || (tag.check && (tag.expect_byte != byte_q));
          // little-endian field lanes
          if (hpos >= 6'd4 && hpos < 6'd8) begin
            riff_d[{hpos[1:0], 3'b000} +: 8] = byte_q;
          end else if (hpos >= 6'd16 && hpos < 6'd20) begin
            fmt_d[{hpos[1:0], 3'b000} +: 8] = byte_q;
          end else if (hpos >= 6'd20 && hpos < 6'd22) begin
            fmttag_d[{hpos[0], 3'b000} +: 8] = byte_q;
          end else if (hpos >= 6'd22 && hpos < 6'd24) begin
            chan_d[{hpos[0], 3'b000} +: 8] = byte_q;
          end else if (hpos >= 6'd24 && hpos < 6'd28) begin
            rate_d[{hpos[1:0], 3'b000} +: 8] = byte_q;
          end else if (hpos >= 6'd28 && hpos < 6'd32) begin
            brate_d[{hpos[1:0], 3'b000} +: 8] = byte_q;
          end else if (hpos >= 6'd32 && hpos < 6'd34) begin
            balign_d[{hpos[0], 3'b000} +: 8] = byte_q;
          end else if (hpos >= 6'd34 && hpos < 6'd36) begin
            bits_d[{hpos[0], 3'b000} +: 8] = byte_q;
          end else if (hpos >= 6'd40 && hpos < 6'd44) begin
            dsize_d[{hpos[1:0], 3'b000} +: 8] = byte_q;
          end
          if (hpos >= POS_HDR_LAST) begin
            pos_d       = HEADER_BYTES;
            mism_d      = 1'b0;
            phase_d     = (hdr_st == ST_OK) ? PH_DATA : PH_IDLE;
            push_o      = 1'b1;
            pair_o.res0 = hdr_r;
            if (end_q && (hdr_st == ST_OK)) begin
              pair_o.two  = 1'b1;
              pair_o.res1 = eof_r;
              phase_d     = PH_IDLE;
            end
          end else begin
            pos_d   = pos_e + 32'd1;
            phase_d = PH_HEADER;
            if (end_q) begin
              push_o      = 1'b1;
              pair_o.res0 = eof_r;
              phase_d     = PH_IDLE;
            end
          end
        end
        PH_DATA: begin
          pos_d  = pos_max ? pos_q : pos_q + 32'd1;
          mism_d = mism_q || pos_max;
          if (!is8 && !count[0]) begin
            low_d = byte_q;
          end
          if (have) begin
            push_o      = 1'b1;
            pair_o.res0 = smp_r;
            if (stereo) begin
              tog_d = !tog_q;
            end
          end
          if (end_q) begin
            phase_d = PH_IDLE;
            push_o  = 1'b1;
            if (have) begin
              pair_o.two  = 1'b1;
              pair_o.res1 = eof_r;
            end else begin
              pair_o.res0 = eof_r;
            end
          end
        end
        default: begin
          // idle: bytes are dropped until the next start of file
        end
      endcase
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PH_HEADER;
      mism_q   <= 1'b0;
      riff_q   <= '0;
      fmt_q    <= '0;
      fmttag_q <= '0;
      chan_q   <= '0;
      rate_q   <= '0;
      brate_q  <= '0;
      balign_q <= '0;
      bits_q   <= '0;
      dsize_q  <= '0;
      low_q    <= '0;
      tog_q    <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      mism_q   <= mism_d;
      riff_q   <= riff_d;
      fmt_q    <= fmt_d;
      fmttag_q <= fmttag_d;
      chan_q   <= chan_d;
      rate_q   <= rate_d;
      brate_q  <= brate_d;
      balign_q <= balign_d;
      bits_q   <= bits_d;
      dsize_q  <= dsize_d;
      low_q    <= low_d;
      tog_q    <= tog_d;
    end
  end

  // byte rate and block align checks, one multiply then one compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q     <= '0;
      aprod_q    <= '0;
      rate_ok_q  <= 1'b0;
      align_ok_q <= 1'b0;
    end else if (consume && (phase_e_s == PH_HEADER)) begin
      if (hpos == POS_RATE_MUL) begin
        prod_q <= prod_d;
      end
      if (hpos == POS_RATE_CMP) begin
        rate_ok_q <= {16'd0, brate_q} == prod_q;
      end
      if (hpos == POS_ALIGN_MUL) begin
        aprod_q <= aprod_d;
      end
      if (hpos == POS_ALIGN_CMP) begin
        align_ok_q <= {13'd0, balign_q} == aprod_q;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_eight_bit_q <= 1'b1;
    end else if (cfg_we_i) begin
      shift_eight_bit_q <= cfg_wdata_i;
    end
  end

  // data phase only follows a header of a supported format
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (pos_q >= HEADER_BYTES))
    else $error("data phase before header end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEADER) |-> (pos_q < HEADER_BYTES))
    else $error("header phase past header end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> fmt_supp)
    else $error("data phase with unsupported format");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && pair_o.two) |-> (pair_o.res1.kind == KIND_END))
    else $error("second result of a byte is not an end status");

endmodule

// ===== hdl/wavhc_pair_fifo.sv =====
// result buffer: one entry per byte, drained as one or two output beats
module wavhc_pair_fifo import wavhc_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pair_t         pair_i,
  output logic          room_o,
  wavhc_result_if.source out_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  pair_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;
  logic            sub_q, sub_d;

  pair_t cur;
  res_t  res;
  logic  last;
  logic  pop_beat;
  logic  pop_entry;

  assign room_o = count_q < CntW'(Depth);

  // head entry and beat select
  assign cur       = mem_q[rd_q];
  assign res       = sub_q ? cur.res1 : cur.res0;
  assign last      = !cur.two || sub_q;
  assign pop_beat  = out_o.valid && out_o.ready;
  assign pop_entry = pop_beat && last;

  assign out_o.valid           = count_q != '0;
  assign out_o.result_kind     = res.kind;
  assign out_o.sample_value    = res.value;
  assign out_o.sample_channel  = res.chan;
  assign out_o.status_code     = res.status;
  assign out_o.sample_rate     = res.rate;
  assign out_o.channel_count   = res.chans;
  assign out_o.bits_per_sample = res.bits;
  assign out_o.last_of_run     = last;

  // pointers, fill count and beat index
  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    sub_d   = sub_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (pop_entry) begin
      rd_d  = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      sub_d = 1'b0;
    end else if (pop_beat) begin
      sub_d = 1'b1;
    end
    if (push_i && !pop_entry) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_entry) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
      sub_q   <= 1'b0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
      sub_q   <= sub_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= pair_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result buffer overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_entry) |=> (count_q == $past(count_q) + 1'b1))
    else $error("fill count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_beat && cur.two && !sub_q) |=> (sub_q && (count_q != '0)))
    else $error("second beat of a two-result entry lost");

endmodule

// ===== hdl/wav_header_check_and_sample_unpack_top.sv =====
// top level of the wav header check and sample unpacker
//
// Input channel in_i carries one file byte per beat with file_start and
// file_end flags. The first 44 bytes are the canonical header; on the last
// header byte one header status beat goes out (rate, channels, bits), then
// each data byte yields a sample beat (16-bit samples on every second byte),
// and the byte marked file_end adds an end status beat. last_of_run marks
// the final beat caused by one byte.
// A byte accepted into the input register is decoded there and its results
// are registered in the result buffer, which drives out_o.
// Throughput: one byte per cycle while the result buffer has room; a byte with
// two results holds the output for both of its beats, and the input stalls
// once the input register and the result buffer (FifoDepth entries) are full.
// When the receiver stalls, results wait in the buffer and the input keeps
// accepting until that buffer fills.
// Reset: parse restarts at header byte 0, buffer empty, 8-bit offset on.
// cfg_we_i/cfg_wdata_i write the 8-bit offset enable; the user must write it only while idle.
module wav_header_check_and_sample_unpack_top import wavhc_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  wavhc_byte_if.sink     in_i,
  wavhc_result_if.source out_o
);

  logic  room;
  logic  push;
  pair_t pair;

  // header parse and sample decode
  wavhc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .room_i      (room),
    .push_o      (push),
    .pair_o      (pair)
  );

  // result buffer and beat serializer
  wavhc_pair_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pair_i (pair),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

// ===== verif/wavhc_checker.sv =====
// scoreboard for the wav header check and sample unpacker: predicts and checks result beats
`timescale 1ns / 100ps

module wavhc_checker import wavhc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  wavhc_byte_if       bytes_i,
  wavhc_result_if     results_i,
  output int unsigned fail_count_o,
  output int unsigned beats_due_o
);

  // tag characters in file order: RIFF, WAVE, fmt , data
  localparam logic [127:0] TAG_TEXT = "RIFFWAVEfmt data";

  typedef struct packed {
    res_t res;
    logic last;
  } beat_t;

  beat_t       beats_due[$];
  int unsigned fails;

  // predicted block state
  logic        offset_on;
  logic [31:0] pos_q;
  phase_e      phase_q;
  logic        fault_q;
  logic [31:0] riff_q, fmt_len_q, rate_q, brate_q, dsize_q;
  logic [15:0] fmt_tag_q, chans_q, align_q, bits_q;
  logic [7:0]  low_q;
  logic        right_next_q;

  task automatic new_file();
    pos_q        = '0;
    phase_q      = PH_HEADER;
    fault_q      = 1'b0;
    riff_q       = '0;
    fmt_len_q    = '0;
    fmt_tag_q    = '0;
    chans_q      = '0;
    rate_q       = '0;
    brate_q      = '0;
    align_q      = '0;
    bits_q       = '0;
    dsize_q      = '0;
    low_q        = '0;
    right_next_q = 1'b0;
  endtask

  // tag compare and little-endian field assembly for one header byte
  task automatic take_header(input logic [31:0] p, input logic [7:0] b);
    int t;
    t = -1;
    if (p < 32'd4) t = int'(p);
    else if (p >= 32'd8 && p < 32'd16) t = int'(p) - 4;
    else if (p >= 32'd36 && p < 32'd40) t = int'(p) - 24;
    if (t >= 0 && TAG_TEXT[127 - 8*t -: 8] != b) fault_q = 1'b1;

    // 32-bit fields start on multiples of four, 16-bit ones on even positions
    if (p >= 32'd4 && p < 32'd8) riff_q[8*p[1:0] +: 8] = b;
    else if (p >= 32'd16 && p < 32'd20) fmt_len_q[8*p[1:0] +: 8] = b;
    else if (p >= 32'd20 && p < 32'd22) fmt_tag_q[8*p[0] +: 8] = b;
    else if (p >= 32'd22 && p < 32'd24) chans_q[8*p[0] +: 8] = b;
    else if (p >= 32'd24 && p < 32'd28) rate_q[8*p[1:0] +: 8] = b;
    else if (p >= 32'd28 && p < 32'd32) brate_q[8*p[1:0] +: 8] = b;
    else if (p >= 32'd32 && p < 32'd34) align_q[8*p[0] +: 8] = b;
    else if (p >= 32'd34 && p < 32'd36) bits_q[8*p[0] +: 8] = b;
    else if (p >= 32'd40 && p < 32'd44) dsize_q[8*p[1:0] +: 8] = b;
  endtask

  // header checks with exact arithmetic, then the format support check
  function automatic status_e header_verdict();
    logic [63:0] align_want, brate_want;
    align_want = 64'(bits_q / 16'd8) * 64'(chans_q);
    brate_want = 64'(rate_q) * 64'(align_q);
    if (fault_q || fmt_len_q != FMT_LEN || fmt_tag_q != PCM_FORMAT
        || 64'(align_q) != align_want || 64'(brate_q) != brate_want
        || 33'(dsize_q) + 33'(HEADER_BYTES) != 33'(riff_q) + 33'd8)
      return ST_BAD_HEADER;
    if ((bits_q != BITS_EIGHT && bits_q != BITS_SIXTEEN)
        || (chans_q != CHANS_MONO && chans_q != CHANS_STEREO))
      return ST_UNSUPPORTED;
    return ST_OK;
  endfunction

  // counted data must equal the declared size in whole frames
  function automatic status_e end_verdict(input logic [63:0] counted);
    if (fault_q || counted != 64'(dsize_q) || align_q == 16'd0
        || counted % 64'(align_q) != 64'd0)
      return ST_LEN_MISMATCH;
    return ST_OK;
  endfunction

  task automatic emit(input res_t r);
    beats_due.push_back('{res: r, last: 1'b0});
  endtask

  // expected beats for one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic start, input logic fin);
    res_t        r;
    int unsigned depth_before;
    logic [31:0] count;
    logic        have;
    status_e     st;
    depth_before = beats_due.size();
    if (start) new_file();
    case (phase_q)
      PH_HEADER: begin
        take_header(pos_q, b);
        if (pos_q >= HEADER_BYTES - 32'd1) begin
          st       = header_verdict();
          r        = '0;
          r.kind   = KIND_HEADER;
          r.status = st;
          r.rate   = rate_q;
          r.chans  = chans_q;
          r.bits   = bits_q;
          emit(r);
          pos_q   = HEADER_BYTES;
          fault_q = 1'b0;
          phase_q = (st == ST_OK) ? PH_DATA : PH_IDLE;
          // file ends right on the last header byte
          if (fin && st == ST_OK) begin
            r        = '0;
            r.kind   = KIND_END;
            r.status = end_verdict(64'd0);
            emit(r);
            phase_q = PH_IDLE;
          end
        end else begin
          pos_q = pos_q + 32'd1;
          // truncated header
          if (fin) begin
            r        = '0;
            r.kind   = KIND_END;
            r.status = ST_TRUNCATED;
            emit(r);
            phase_q = PH_IDLE;
          end
        end
      end
      PH_DATA: begin
        count = pos_q - HEADER_BYTES;
        // position saturates and flags an overflow
        if (pos_q == '1) fault_q = 1'b1;
        else pos_q = pos_q + 32'd1;
        r    = '0;
        r.kind = KIND_SAMPLE;
        have = 1'b0;
        if (bits_q == BITS_EIGHT) begin
          r.value = offset_on ? {8'h00, b} - 16'd128 : {8'h00, b};
          have    = 1'b1;
        end else if (!count[0]) begin
          low_q = b;
        end else begin
          r.value = {b, low_q};
          have    = 1'b1;
        end
        if (have) begin
          r.chan = (chans_q == CHANS_STEREO) && !right_next_q;
          emit(r);
          if (chans_q == CHANS_STEREO) right_next_q = !right_next_q;
        end
        if (fin) begin
          r        = '0;
          r.kind   = KIND_END;
          r.status = end_verdict(64'(count) + 64'd1);
          emit(r);
          phase_q = PH_IDLE;
        end
      end
      default: begin
        // idle: bytes and end flags are dropped until the next start
      end
    endcase
    if (beats_due.size() > depth_before) beats_due[beats_due.size() - 1].last = 1'b1;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  // compare one accepted result beat with the oldest expectation
  task automatic check_beat();
    beat_t want;
    if (beats_due.size() == 0) begin
      $display("%0t: result beat with none expected, got kind %0h status %0h value %0h",
               $time, results_i.result_kind, results_i.status_code, results_i.sample_value);
      fails++;
    end else begin
      want = beats_due.pop_front();
      compare_field("result_kind", 32'(want.res.kind), 32'(results_i.result_kind));
      compare_field("sample_value", 32'(want.res.value), 32'(results_i.sample_value));
      compare_field("sample_channel", 32'(want.res.chan), 32'(results_i.sample_channel));
      compare_field("status_code", 32'(want.res.status), 32'(results_i.status_code));
      compare_field("sample_rate", want.res.rate, results_i.sample_rate);
      compare_field("channel_count", 32'(want.res.chans), 32'(results_i.channel_count));
      compare_field("bits_per_sample", 32'(want.res.bits), 32'(results_i.bits_per_sample));
      compare_field("last_of_run", 32'(want.last), 32'(results_i.last_of_run));
    end
  endtask

  // watch config writes and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_file();
      offset_on = 1'b1;
      beats_due.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) offset_on = cfg_wdata_i;
      if (bytes_i.valid && bytes_i.ready)
        decode_byte(bytes_i.data_byte, bytes_i.file_start, bytes_i.file_end);
      if (results_i.valid && results_i.ready) check_beat();
    end
    fail_count_o <= fails;
    beats_due_o  <= beats_due.size();
  end

endmodule

// ===== verif/tb_wav_header_check_and_sample_unpack_top.sv =====
// testbench top for the wav header check and sample unpacker: stimulus and verdict
`timescale 1ns / 100ps

module tb_wav_header_check_and_sample_unpack_top;
  import wavhc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic        cfg_wdata;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned phase_bytes = 0;
  int unsigned fail_count;
  int unsigned beats_due;
  logic [7:0]  wav_hdr [0:43];

  wavhc_byte_if   in_bus();
  wavhc_result_if out_bus();

  wav_header_check_and_sample_unpack_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  wavhc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .bytes_i      (in_bus),
    .results_i    (out_bus),
    .fail_count_o (fail_count),
    .beats_due_o  (beats_due)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result receiver: random back-pressure
  always @(posedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // run limit
  initial begin
    #2_000_000;
    $display("wav_header_check_and_sample_unpack_top: mismatch");
    $finish;
  end

  // one byte beat, with random idle cycles ahead of it
  task automatic put_byte(input logic [7:0] b, input logic first, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_byte  <= b;
    in_bus.file_start <= first;
    in_bus.file_end   <= last;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    phase_bytes++;
  endtask

  task automatic put_le(input int unsigned pos, input logic [31:0] v, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) wav_hdr[pos + i] = v[8*i +: 8];
  endtask

  task automatic put_tag(input int unsigned pos, input logic [31:0] t);
    for (int unsigned i = 0; i < 4; i++) wav_hdr[pos + i] = t[31 - 8*i -: 8];
  endtask

  // consistent canonical header for the given format and data size
  task automatic build_header(input logic [15:0] chans, input logic [15:0] bits,
                              input logic [31:0] rate, input logic [31:0] dsize);
    logic [15:0] align;
    logic [31:0] brate;
    align = (bits / 16'd8) * chans;
    brate = rate * {16'd0, align};
    put_tag(0, "RIFF");
    put_le(4, dsize + DATA_SIZE_GAP[31:0], 4);
    put_tag(8, "WAVE");
    put_tag(12, "fmt ");
    put_le(16, FMT_LEN, 4);
    put_le(20, {16'd0, PCM_FORMAT}, 2);
    put_le(22, {16'd0, chans}, 2);
    put_le(24, rate, 4);
    put_le(28, brate, 4);
    put_le(32, {16'd0, align}, 2);
    put_le(34, {16'd0, bits}, 2);
    put_tag(36, "data");
    put_le(40, dsize, 4);
  endtask

  // header bytes from wav_hdr, then random data, extremes now and then
  task automatic stream_file(input int unsigned n_bytes, input logic first, input logic last);
    logic [7:0] b;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if (i < HEADER_BYTES) begin
        b = wav_hdr[i];
      end else if ($urandom_range(3) == 0) begin
        b = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(1) == 1) b = b ^ EIGHT_BIT_FLIP;
      end else begin
        b = 8'($urandom_range(255));
      end
      put_byte(b, first && i == 0, last && i == n_bytes - 1);
    end
  endtask

  // stop sending, wait for every expected beat, then let the pipe settle
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (beats_due != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_shift(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [15:0] chans, bits;
    logic [31:0] rate;
    int unsigned n_data, pick, spot;

    in_bus.valid      = 1'b0;
    in_bus.data_byte  = 8'h00;
    in_bus.file_start = 1'b0;
    in_bus.file_end   = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_shift(1'b1);

    // first file after reset without a start flag: 8-bit mono
    build_header(16'd1, 16'd8, 32'd8000, 32'd4);
    stream_file(48, 1'b0, 1'b1);
    // 16-bit stereo, two frames and a stray low byte
    build_header(16'd2, 16'd16, 32'd44100, 32'd9);
    stream_file(53, 1'b1, 1'b1);
    // end on the last header byte, empty and non-empty declared data
    build_header(16'd2, 16'd8, 32'd22050, 32'd0);
    stream_file(44, 1'b1, 1'b1);
    build_header(16'd1, 16'd16, 32'd48000, 32'd6);
    stream_file(44, 1'b1, 1'b1);
    // one-byte file, then a truncated header, then ignored bytes
    stream_file(1, 1'b1, 1'b1);
    build_header(16'd1, 16'd8, 32'd8000, 32'd0);
    stream_file(20, 1'b1, 1'b1);
    put_byte(8'h5A, 1'b0, 1'b1);
    put_byte(8'hA5, 1'b0, 1'b0);
    // field extremes: top rate, all channels, zero format, top bits, wrapping size
    build_header(16'd1, 16'd8, 32'hFFFF_FFFF, 32'd2);
    stream_file(46, 1'b1, 1'b1);
    build_header(16'hFFFF, 16'd8, 32'd1, 32'd0);
    stream_file(47, 1'b1, 1'b1);
    build_header(16'd0, 16'd0, 32'd0, 32'd0);
    stream_file(45, 1'b1, 1'b1);
    build_header(16'd2, 16'hFFFF, 32'd5, 32'd0);
    stream_file(45, 1'b1, 1'b1);
    build_header(16'd1, 16'd8, 32'd8000, 32'hFFFF_FFFF);
    stream_file(46, 1'b1, 1'b1);
    // each header check broken on its own
    for (int c = 0; c < 6; c++) begin
      build_header(16'd1, 16'd16, 32'd16000, 32'd2);
      case (c)
        0: wav_hdr[38] = "x";
        1: wav_hdr[16] = 8'd18;
        2: wav_hdr[20] = 8'd3;
        3: wav_hdr[32] = wav_hdr[32] ^ 8'h01;
        4: wav_hdr[28] = wav_hdr[28] ^ 8'h01;
        default: wav_hdr[4] = wav_hdr[4] ^ 8'h01;
      endcase
      stream_file(47, 1'b1, 1'b1);
    end
    // data shorter and longer than declared
    build_header(16'd2, 16'd8, 32'd11025, 32'd6);
    stream_file(48, 1'b1, 1'b1);
    stream_file(52, 1'b1, 1'b1);
    // new file starts while samples of the previous one still flow
    build_header(16'd1, 16'd16, 32'd8000, 32'd8);
    stream_file(49, 1'b1, 1'b0);
    build_header(16'd2, 16'd16, 32'd8000, 32'd4);
    stream_file(48, 1'b1, 1'b1);

    // random files over the idling modes and both offset settings
    for (int unsigned p = 0; p < 4; p++) begin
      wait_drained();
      write_shift(p[0]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 40) begin
        pick   = $urandom_range(99);
        chans  = 16'($urandom_range(2, 1));
        bits   = $urandom_range(1) ? BITS_SIXTEEN : BITS_EIGHT;
        rate   = $urandom_range(192000, 4000);
        n_data = $urandom_range(12) * int'(bits / 16'd8) * int'(chans);
        if (pick < 62) begin
          // well-formed file, sometimes with a data length off
          build_header(chans, bits, rate, n_data);
          case ($urandom_range(7))
            0: n_data = n_data + $urandom_range(3, 1);
            1: if (n_data != 0) n_data = n_data - 1;
            default: begin
            end
          endcase
          stream_file(HEADER_BYTES + n_data, 1'b1, 1'b1);
        end else if (pick < 70) begin
          // one flipped header bit
          build_header(chans, bits, rate, n_data);
          spot = $urandom_range(43);
          wav_hdr[spot] = wav_hdr[spot] ^ (8'h01 << $urandom_range(7));
          stream_file(HEADER_BYTES + n_data, 1'b1, 1'b1);
        end else if (pick < 77) begin
          // odd sample width or channel count
          bits  = 16'(8 * $urandom_range(4));
          chans = 16'($urandom_range(6));
          build_header(chans, bits, rate, $urandom_range(8));
          stream_file(HEADER_BYTES + $urandom_range(4), 1'b1, 1'b1);
        end else if (pick < 84) begin
          // header cut short
          build_header(chans, bits, rate, n_data);
          stream_file($urandom_range(43, 1), 1'b1, 1'b1);
        end else if (pick < 92) begin
          // no end flag, the next file restarts the parse
          build_header(chans, bits, rate, n_data);
          stream_file(HEADER_BYTES + n_data, 1'b1, 1'b0);
        end else begin
          // noise with random framing flags
          repeat ($urandom_range(12, 1))
            put_byte(8'($urandom_range(255)), $urandom_range(7) == 0, $urandom_range(7) == 0);
        end
      end
    end

    wait_drained();
    if (fail_count == 0)
      $display("wav_header_check_and_sample_unpack_top: match");
    else
      $display("wav_header_check_and_sample_unpack_top: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wavhc_pkg.sv
hdl/wavhc_byte_if.sv
hdl/wavhc_result_if.sv
hdl/wavhc_parser.sv
hdl/wavhc_pair_fifo.sv
hdl/wav_header_check_and_sample_unpack_top.sv
verif/wavhc_checker.sv
verif/tb_wav_header_check_and_sample_unpack_top.sv
